// File: design/btu_pkg.sv
// ----------------------------------------------------------------------------
// btu_pkg: shared types and constants of the binary image thinning unit
// Frame geometry, command codes, register indexes, controller states and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package btu_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = 16;
    localparam int DIM_W       = 9;
    localparam int PIX_W       = 8;
    localparam int CNT_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int NB_N        = 16;
    localparam int J_W         = 5;

    localparam logic [PIX_W-1:0] PIX_BG = 8'd255;
    localparam int NB_MIN = 2;
    localparam int NB_MAX = 6;
    localparam logic [CNT_W-1:0] PASS_LIMIT_RST = 8'd100;
    localparam logic [DIM_W-1:0] DIM_RST = 9'd256;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_code_t;

    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_PASS_LIMIT   = 2'd2,
        CFG_NONE         = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_GATHER,
        ST_DECIDE,
        ST_PASS_END,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic req_ready;
        logic do_write;
        logic out_load;
        logic out_from_ram;
        logic run_init;
        logic pass_init;
        logic copy_rd;
        logic copy_wr;
        logic visit_init;
        logic gather;
        logic decide;
        logic pass_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic      req_valid;
        cmd_code_t req_cmd;
        logic      out_free;
        logic      copy_last;
        logic      visit_empty;
        logic      x_last;
        logic      y_last;
        logic      gather_last;
        logic      changed;
        logic      limit_zero;
        logic      k_last;
    } dp_status_t;

endpackage

// File: design/btu_req_if.sv
// ----------------------------------------------------------------------------
// btu_req_if: request channel
// Valid/ready channel that carries one command with its address and pixel.
// ----------------------------------------------------------------------------
interface btu_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [15:0] pixel_addr;
    logic [7:0] pixel_in;

    modport source (output valid, output cmd, output pixel_addr, output pixel_in,
                    input ready);
    modport sink   (input valid, input cmd, input pixel_addr, input pixel_in,
                    output ready);
endinterface

// File: design/btu_rsp_if.sv
// ----------------------------------------------------------------------------
// btu_rsp_if: response channel
// Valid/ready channel that carries one result per request.
// ----------------------------------------------------------------------------
interface btu_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic [7:0] passes_run;
    logic       converged;

    modport source (output valid, output pixel_out, output passes_run,
                    output converged, input ready);
    modport sink   (input valid, input pixel_out, input passes_run,
                    input converged, output ready);
endinterface

// File: design/btu_ram.sv
// ----------------------------------------------------------------------------
// btu_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module btu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/btu_ctrl.sv
// ----------------------------------------------------------------------------
// btu_ctrl: thinning unit controller
// Sequences request handling, snapshot copy, neighbourhood gather and passes.
// ----------------------------------------------------------------------------
module btu_ctrl
    import btu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.req_ready = status.out_free;
                if (status.req_valid && status.out_free)
                begin
                    case (status.req_cmd)
                        CMD_WRITE:
                        begin
                            cmd.do_write = 1'b1;
                            cmd.out_load = 1'b1;
                        end
                        CMD_READ:
                        begin
                            state_next = ST_RD_WAIT;
                        end
                        CMD_RUN:
                        begin
                            cmd.run_init  = 1'b1;
                            cmd.pass_init = 1'b1;
                            state_next = status.limit_zero ? ST_FINISH : ST_COPY_RD;
                        end
                        default:
                        begin
                            cmd.out_load = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                cmd.out_load     = 1'b1;
                cmd.out_from_ram = 1'b1;
                state_next = ST_IDLE;
            end
            ST_COPY_RD:
            begin
                cmd.copy_rd = 1'b1;
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                cmd.copy_wr = 1'b1;
                if (!status.copy_last)
                begin
                    state_next = ST_COPY_RD;
                end
                else if (status.visit_empty)
                begin
                    state_next = ST_PASS_END;
                end
                else
                begin
                    cmd.visit_init = 1'b1;
                    state_next = ST_GATHER;
                end
            end
            ST_GATHER:
            begin
                cmd.gather = 1'b1;
                if (status.gather_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = (status.x_last && status.y_last) ? ST_PASS_END : ST_GATHER;
            end
            ST_PASS_END:
            begin
                cmd.pass_done = 1'b1;
                if (!status.changed || status.k_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.pass_init = 1'b1;
                    state_next = ST_COPY_RD;
                end
            end
            ST_FINISH:
            begin
                cmd.out_load = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.req_ready |-> state_reg == ST_IDLE)
        else $error("request taken outside idle");

    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && status.req_valid && status.out_free
         && status.req_cmd == CMD_READ) |=> state_reg == ST_RD_WAIT)
        else $error("read not followed by read wait");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |=> state_reg == ST_IDLE)
        else $error("finish did not return to idle");

endmodule

// File: design/btu_dp.sv
// ----------------------------------------------------------------------------
// btu_dp: thinning unit datapath
// Frame and snapshot stores, scan counters, neighbourhood rule and results.
// ----------------------------------------------------------------------------
module btu_dp
    import btu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    btu_req_if.sink               req_ch,
    btu_rsp_if.source             rsp_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status
);

    logic [DIM_W-1:0]  width_reg, height_reg;
    logic [CNT_W-1:0]  limit_reg;
    logic [CNT_W-1:0]  passes_reg, k_reg;
    logic              conv_reg, changed_reg;
    logic              out_valid_reg;
    logic [PIX_W-1:0]  out_pix_reg, out_passes_reg;
    logic              out_conv_reg;
    logic [ADDR_W-1:0] copy_addr_reg, row_mid_reg;
    logic [DIM_W-1:0]  col_reg, row_reg, x_reg, y_reg;
    logic [J_W-1:0]    j_reg;
    logic [NB_N-1:0]   nb_reg;

    logic [DIM_W-1:0]  w, h;
    logic [ADDR_W-1:0] w16, x16, up, dn, dd, base, xo, center;
    logic [J_W-1:0]    jm1;
    logic              frame_we, snap_rdata;
    logic [ADDR_W-1:0] frame_waddr, frame_raddr, snap_raddr;
    logic [PIX_W-1:0]  frame_wdata, frame_rdata;
    logic [7:0]        pv, trans;
    logic [3:0]        a_cnt, b_cnt;
    logic              guard_ok, square, diag, keep, remove;

    always_comb
    begin
        if (width_reg == '0) w = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH)) w = DIM_W'(MAX_WIDTH);
        else w = width_reg;
        if (height_reg == '0) h = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT)) h = DIM_W'(MAX_HEIGHT);
        else h = height_reg;
    end

    assign w16    = ADDR_W'(w);
    assign x16    = ADDR_W'(x_reg);
    assign up     = row_mid_reg - w16;
    assign dn     = row_mid_reg + w16;
    assign dd     = dn + w16;
    assign center = row_mid_reg + x16;

    // neighbourhood read order: centre, p0..p7, then the outer ring
    always_comb
    begin
        case (j_reg[3:0])
            4'd0:    begin base = row_mid_reg; xo = x16;            end
            4'd1:    begin base = up;          xo = x16;            end
            4'd2:    begin base = up;          xo = x16 + 16'd1;    end
            4'd3:    begin base = row_mid_reg; xo = x16 + 16'd1;    end
            4'd4:    begin base = dn;          xo = x16 + 16'd1;    end
            4'd5:    begin base = dn;          xo = x16;            end
            4'd6:    begin base = dn;          xo = x16 - 16'd1;    end
            4'd7:    begin base = row_mid_reg; xo = x16 - 16'd1;    end
            4'd8:    begin base = up;          xo = x16 - 16'd1;    end
            4'd9:    begin base = up;          xo = x16 + 16'd2;    end
            4'd10:   begin base = row_mid_reg; xo = x16 + 16'd2;    end
            4'd11:   begin base = dn;          xo = x16 + 16'd2;    end
            4'd12:   begin base = dd;          xo = x16 + 16'd2;    end
            4'd13:   begin base = dd;          xo = x16 + 16'd1;    end
            4'd14:   begin base = dd;          xo = x16;            end
            default: begin base = dd;          xo = x16 - 16'd1;    end
        endcase
    end

    assign snap_raddr = base + xo;
    assign jm1        = j_reg - J_W'(1);

    // thinning rule over the gathered neighbourhood
    assign pv       = nb_reg[8:1];
    assign trans    = ~pv & {pv[0], pv[7:1]};
    assign a_cnt    = 4'($countones(trans));
    assign b_cnt    = 4'($countones(pv));
    assign guard_ok = ({1'b0, y_reg} + 10'd2 < {1'b0, h})
                   && ({1'b0, x_reg} + 10'd2 < {1'b0, w});
    assign square   = pv[2] && pv[3] && pv[4] && guard_ok && !(|nb_reg[15:9]);
    assign diag     = (!pv[0] && !pv[1] && !pv[2] && !pv[5] && pv[4] && pv[6])
                   || (!pv[2] && !pv[3] && !pv[4] && !pv[7] && pv[0] && pv[6]);
    assign keep     = k_reg[0] ? (pv[2] && pv[4] && (pv[0] || pv[6]))
                               : (pv[0] && pv[6] && (pv[2] || pv[4]));
    assign remove   = nb_reg[0] && !square
                   && b_cnt >= 4'(NB_MIN) && b_cnt <= 4'(NB_MAX)
                   && (a_cnt == 4'd1 || diag) && !keep;

    assign frame_we    = cmd.do_write || (cmd.decide && remove);
    assign frame_waddr = cmd.do_write ? req_ch.pixel_addr : center;
    assign frame_wdata = cmd.do_write ? req_ch.pixel_in : PIX_BG;
    assign frame_raddr = cmd.copy_rd ? copy_addr_reg : req_ch.pixel_addr;

    btu_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_frame (
        .clk   (clk),
        .we    (frame_we),
        .waddr (frame_waddr),
        .wdata (frame_wdata),
        .raddr (frame_raddr),
        .rdata (frame_rdata)
    );

    btu_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_snap (
        .clk   (clk),
        .we    (cmd.copy_wr),
        .waddr (copy_addr_reg),
        .wdata (frame_rdata == '0),
        .raddr (snap_raddr),
        .rdata (snap_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DIM_RST;
            height_reg    <= DIM_RST;
            limit_reg     <= PASS_LIMIT_RST;
            passes_reg    <= '0;
            conv_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                    CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                    CFG_PASS_LIMIT:   limit_reg  <= cfg_data[CNT_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.run_init)
            begin
                passes_reg <= '0;
                conv_reg   <= 1'b0;
            end
            if (cmd.pass_done)
            begin
                passes_reg <= k_reg + CNT_W'(1);
                if (!changed_reg)
                begin
                    conv_reg <= 1'b1;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pix_reg    <= cmd.out_from_ram ? frame_rdata : '0;
            out_passes_reg <= passes_reg;
            out_conv_reg   <= conv_reg;
        end
        if (cmd.run_init)
        begin
            k_reg <= '0;
        end
        if (cmd.pass_done)
        begin
            k_reg <= k_reg + CNT_W'(1);
        end
        if (cmd.pass_init)
        begin
            copy_addr_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            changed_reg   <= 1'b0;
        end
        if (cmd.copy_wr)
        begin
            copy_addr_reg <= copy_addr_reg + ADDR_W'(1);
            if (col_reg == w - DIM_W'(1))
            begin
                col_reg <= '0;
                row_reg <= row_reg + DIM_W'(1);
            end
            else
            begin
                col_reg <= col_reg + DIM_W'(1);
            end
        end
        if (cmd.visit_init)
        begin
            x_reg       <= DIM_W'(1);
            y_reg       <= DIM_W'(1);
            row_mid_reg <= w16;
            j_reg       <= '0;
        end
        if (cmd.gather)
        begin
            j_reg <= j_reg + J_W'(1);
            if (j_reg != '0)
            begin
                nb_reg[jm1[3:0]] <= snap_rdata;
            end
        end
        if (cmd.decide)
        begin
            j_reg <= '0;
            if (remove)
            begin
                changed_reg <= 1'b1;
            end
            if (status.x_last)
            begin
                x_reg       <= DIM_W'(1);
                y_reg       <= y_reg + DIM_W'(1);
                row_mid_reg <= row_mid_reg + w16;
            end
            else
            begin
                x_reg <= x_reg + DIM_W'(1);
            end
        end
    end

    always_comb
    begin
        status.req_valid   = req_ch.valid;
        status.req_cmd     = cmd_code_t'(req_ch.cmd);
        status.out_free    = !out_valid_reg || rsp_ch.ready;
        status.copy_last   = (col_reg == w - DIM_W'(1)) && (row_reg == h - DIM_W'(1));
        status.visit_empty = (w < DIM_W'(3)) || (h < DIM_W'(3));
        status.x_last      = (x_reg + DIM_W'(2) == w);
        status.y_last      = (y_reg + DIM_W'(2) == h);
        status.gather_last = (j_reg == J_W'(NB_N));
        status.changed     = changed_reg;
        status.limit_zero  = (limit_reg == '0);
        status.k_last      = (k_reg + CNT_W'(1) == limit_reg);
    end

    assign req_ch.ready      = cmd.req_ready;
    assign rsp_ch.valid      = out_valid_reg;
    assign rsp_ch.pixel_out  = out_pix_reg;
    assign rsp_ch.passes_run = out_passes_reg;
    assign rsp_ch.converged  = out_conv_reg;

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || rsp_ch.ready))
        else $error("result loaded over an untaken result");

endmodule

// File: design/binary_image_thinning_unit.sv
// ----------------------------------------------------------------------------
// binary_image_thinning_unit: top level of the binary image thinning unit
// Holds an 8-bit frame and thins its zero-valued foreground in passes.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  req_ch   | in  | valid / ready      | cmd, pixel_addr, pixel_in
//  rsp_ch   | out | valid / ready      | pixel_out, passes_run, converged
//  cfg      | in  | cfg_we, no wait    | cfg_index, cfg_data
//
//  Write and unknown requests load the result register when taken; a read
//  waits in the read-wait state for the registered frame RAM read. A pass
//  copies the frame to the snapshot store over the frame RAM port (a read
//  and a write state per pixel), then per interior pixel makes 16 snapshot
//  RAM reads, takes the last read data and decides (with fewer than 3 rows
//  or columns, only the copy and pass end). A zero pass limit goes to finish.
//  Reset clears control state and config registers; the frame stores are
//  undefined until written. A waiting result holds the output register;
//  a new request is taken only when that register is free or being drained.
// ----------------------------------------------------------------------------
module binary_image_thinning_unit
    import btu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    btu_req_if.sink               req_ch,
    btu_rsp_if.source             rsp_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // command bundle from the controller, status bundle back from the datapath
    ctrl_cmd_t  cmd;
    dp_status_t status;

    btu_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    btu_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_ch),
        .rsp_ch    (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: tb/btu_thin_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btu_thin_checker: response predictor and scoreboard for the thinning unit
// Watches the config port and both channels, keeps its own frame image and
// thinning state, and checks every response against the oldest prediction.
// ----------------------------------------------------------------------------
module btu_thin_checker
    import btu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    btu_req_if                    req_ch,
    btu_rsp_if                    rsp_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    fail_count
);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [CNT_W-1:0] passes;
        logic             conv;
    } thin_result_t;

    logic [PIX_W-1:0] frame_img [0:STORE_DEPTH-1];
    bit               fg_snap   [0:STORE_DEPTH-1];
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] passes_done;
    logic             conv_flag;
    thin_result_t     expected_q [$];

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return int'(v);
    endfunction

    // one run command: passes until nothing is removed or the limit is hit
    function automatic void thin_frame();
        int w, h, k, x, y, i, a, b, up, mid, dn, dd;
        bit p [8];
        bit changed, c, keep, ring;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        passes_done = '0;
        conv_flag = 1'b0;
        for (k = 0; k < int'(limit_reg); k++) begin
            changed = 1'b0;
            for (i = 0; i < w * h; i++)
                fg_snap[i] = (frame_img[i] == '0);
            for (y = 1; y + 1 < h; y++) begin
                for (x = 1; x + 1 < w; x++) begin
                    up = (y - 1) * w; mid = y * w; dn = (y + 1) * w;
                    if (!fg_snap[mid + x]) continue;
                    p[0] = fg_snap[up + x];     p[1] = fg_snap[up + x + 1];
                    p[2] = fg_snap[mid + x + 1]; p[3] = fg_snap[dn + x + 1];
                    p[4] = fg_snap[dn + x];     p[5] = fg_snap[dn + x - 1];
                    p[6] = fg_snap[mid + x - 1]; p[7] = fg_snap[up + x - 1];
                    // keep the upper-left corner of an isolated 2x2 square
                    if (p[2] && p[3] && p[4] && y + 2 < h && x + 2 < w) begin
                        dd = (y + 2) * w;
                        ring = fg_snap[up + x + 2] | fg_snap[mid + x + 2]
                             | fg_snap[dn + x + 2] | fg_snap[dd + x + 2]
                             | fg_snap[dd + x + 1] | fg_snap[dd + x]
                             | fg_snap[dd + x - 1];
                        if (!ring) continue;
                    end
                    a = 0; b = 0;
                    for (i = 0; i < 8; i++) begin
                        a += (!p[i] && p[(i + 1) % 8]);
                        b += p[i];
                    end
                    if (b < NB_MIN || b > NB_MAX) continue;
                    c = ((p[0] + p[1] + p[2] + p[5] == 0) && (p[4] + p[6] == 2))
                     || ((p[2] + p[3] + p[4] + p[7] == 0) && (p[0] + p[6] == 2));
                    if (a != 1 && !c) continue;
                    if (k % 2 == 0) keep = p[0] && p[6] && (p[2] || p[4]);
                    else            keep = p[2] && p[4] && (p[0] || p[6]);
                    if (!keep) begin
                        frame_img[mid + x] = PIX_BG;
                        changed = 1'b1;
                    end
                end
            end
            passes_done = CNT_W'(k + 1);
            if (!changed) begin
                conv_flag = 1'b1;
                break;
            end
        end
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n) begin
        thin_result_t got, want;
        if (!rst_n) begin
            width_reg   = DIM_RST;
            height_reg  = DIM_RST;
            limit_reg   = PASS_LIMIT_RST;
            passes_done = '0;
            conv_flag   = 1'b0;
            fail_count  = 0;
            expected_q.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_FRAME_WIDTH:  width_reg  = cfg_data;
                    CFG_FRAME_HEIGHT: height_reg = cfg_data;
                    CFG_PASS_LIMIT:   limit_reg  = cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready) begin
                want.pixel = '0;
                case (cmd_code_t'(req_ch.cmd))
                    CMD_WRITE: frame_img[req_ch.pixel_addr] = req_ch.pixel_in;
                    CMD_RUN:   thin_frame();
                    CMD_READ:  want.pixel = frame_img[req_ch.pixel_addr];
                    default: ;
                endcase
                want.passes = passes_done;
                want.conv   = conv_flag;
                expected_q.push_back(want);
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = '{rsp_ch.pixel_out, rsp_ch.passes_run, rsp_ch.converged};
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected response pixel=%0d passes=%0d conv=%0d",
                                 got.pixel, got.passes, got.conv);
                end
                else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: pixel %0d/%0d passes %0d/%0d conv %0d/%0d (exp/got)",
                                     want.pixel, got.pixel, want.passes, got.passes,
                                     want.conv, got.conv);
                    end
                end
            end
        end
    end

endmodule

// File: tb/binary_image_thinning_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_image_thinning_unit_tb: top of the thinning unit testbench
// Loads small frames of foreground blobs, thins them under several frame
// sizes and pass limits, and mixes pixel writes, reads and idle commands in
// random bursts against a stalling receiver; a checker module scores it all.
// ----------------------------------------------------------------------------
module binary_image_thinning_unit_tb;
    import btu_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    fail_count;
    int                    cycles;
    int                    burst_left;
    bit                    hold_go;
    bit                    hold_done;
    logic [ADDR_W-1:0]     extra_addrs [$];

    btu_req_if req_ch();
    btu_rsp_if rsp_ch();

    binary_image_thinning_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_ch    (req_ch),
        .rsp_ch    (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    btu_thin_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_ch     (req_ch),
        .rsp_ch     (rsp_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Send one request: open a new burst with a random gap when the last one
    // is spent, then hold the request until the block takes it.
    task automatic send_request(input cmd_code_t c, input logic [ADDR_W-1:0] a,
                                input logic [PIX_W-1:0] d);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= c;
        req_ch.pixel_addr <= a;
        req_ch.pixel_in   <= d;
        do @(posedge clk); while (!req_ch.ready);
        burst_left--;
    endtask

    // Drop valid and wait for every outstanding response before touching
    // the registers.
    task automatic drain();
        req_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_regs(input logic [DIM_W-1:0] wv, input logic [DIM_W-1:0] hv,
                              input logic [CNT_W-1:0] lv, input bit with_spare);
        cfg_we <= 1'b1;
        if (with_spare) begin
            cfg_index <= CFG_NONE;
            cfg_data  <= CFG_DATA_W'($urandom);
            @(posedge clk);
        end
        cfg_index <= CFG_FRAME_WIDTH;  cfg_data <= wv; @(posedge clk);
        cfg_index <= CFG_FRAME_HEIGHT; cfg_data <= hv; @(posedge clk);
        cfg_index <= CFG_PASS_LIMIT;   cfg_data <= CFG_DATA_W'(lv); @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int eff_dim(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_WIDTH) return MAX_WIDTH;
        return int'(v);
    endfunction

    function automatic logic [PIX_W-1:0] bg_pixel();
        return PIX_W'($urandom_range(1, 255));
    endfunction

    // One phase: registers, a full frame load (blob or lone 2x2 square),
    // then random traffic that keeps reads on written pixels only.
    task automatic run_phase(input logic [DIM_W-1:0] wv, input logic [DIM_W-1:0] hv,
                             input logic [CNT_W-1:0] lv, input bit square,
                             input int n_random, input bit with_spare);
        int w, h, x, y, x0, x1, y0, y1, r;
        logic [ADDR_W-1:0] a;
        logic [PIX_W-1:0]  d;
        bit fg;
        drain();
        write_regs(wv, hv, lv, with_spare);
        w = eff_dim(wv);
        h = eff_dim(hv);
        x0 = $urandom_range(0, w - 1); x1 = $urandom_range(x0, w - 1);
        y0 = $urandom_range(0, h - 1); y1 = $urandom_range(y0, h - 1);
        for (y = 0; y < h; y++) begin
            for (x = 0; x < w; x++) begin
                if (square) fg = (x >= 1 && x <= 2 && y >= 1 && y <= 2);
                else fg = (x >= x0 && x <= x1 && y >= y0 && y <= y1)
                          || ($urandom_range(0, 9) == 0);
                send_request(CMD_WRITE, ADDR_W'(y * w + x), fg ? '0 : bg_pixel());
            end
        end
        if (square) begin
            send_request(CMD_RUN, '0, '0);
            send_request(CMD_READ, ADDR_W'(w + 1), '0);
            send_request(CMD_RUN, '0, '0);
        end
        repeat (n_random) begin
            r = $urandom_range(0, 99);
            d = ($urandom_range(0, 4) < 3) ? '0 : PIX_W'($urandom);
            if (r < 40) begin
                send_request(CMD_WRITE, ADDR_W'($urandom_range(0, w * h - 1)), d);
            end
            else if (r < 48) begin
                a = ADDR_W'($urandom);
                extra_addrs.push_back(a);
                send_request(CMD_WRITE, a, d);
            end
            else if (r < 80) begin
                if (extra_addrs.size() != 0 && $urandom_range(0, 7) == 0)
                    a = extra_addrs[$urandom_range(0, extra_addrs.size() - 1)];
                else
                    a = ADDR_W'($urandom_range(0, w * h - 1));
                send_request(CMD_READ, a, PIX_W'($urandom));
            end
            else if (r < 92) begin
                send_request(CMD_RUN, ADDR_W'($urandom), PIX_W'($urandom));
            end
            else begin
                send_request(CMD_NOP, ADDR_W'($urandom), PIX_W'($urandom));
            end
        end
    endtask

    // Receiver: change stall mode every stretch; once, hold off for a long
    // stretch so the output register fills and the request side backs up.
    initial begin
        int mode, mode_left;
        mode_left = 0;
        mode = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go && !hold_done) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: rsp_ch.ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    // Watchdog: advance the cycle count and give up past the limit.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("binary_image_thinning_unit_tb failed");
                $finish;
            end
        end
    end

    initial begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= CFG_FRAME_WIDTH;
        cfg_data          <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= CMD_NOP;
        req_ch.pixel_addr <= '0;
        req_ch.pixel_in   <= '0;
        burst_left = 0;
        hold_go    = 1'b0;
        hold_done  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: address and pixel extremes at reset geometry, idle
        // commands, and status before any run.
        extra_addrs.push_back(16'hFFFF);
        extra_addrs.push_back(16'h5555);
        extra_addrs.push_back(16'h0000);
        send_request(CMD_WRITE, 16'hFFFF, 8'hFF);
        send_request(CMD_WRITE, 16'h5555, 8'hAA);
        send_request(CMD_WRITE, 16'h0000, 8'h00);
        send_request(CMD_READ, 16'hFFFF, 8'h00);
        send_request(CMD_READ, 16'h5555, 8'hFF);
        send_request(CMD_READ, 16'h0000, 8'h55);
        send_request(CMD_NOP, 16'hAAAA, 8'h55);

        // Zero sizes saturate to one pixel; zero pass limit runs nothing,
        // then a tiny frame gives one empty pass.
        run_phase(9'd0, 9'd0, 8'd0, 1'b0, 0, 1'b1);
        send_request(CMD_RUN, '0, '0);
        run_phase(9'd0, 9'd0, 8'd1, 1'b0, 0, 1'b0);
        send_request(CMD_RUN, '0, '0);
        // isolated 2x2 square: the corner guard keeps its upper-left pixel
        run_phase(9'd4, 9'd4, 8'd255, 1'b1, 0, 1'b0);

        // Widest frame, with the long receiver hold-off while it loads:
        // start the hold only once the earlier traffic is drained.
        drain();
        hold_go = 1'b1;
        run_phase(9'd511, 9'd1, 8'd255, 1'b0, 40, 1'b0);
        run_phase(9'd1, 9'd256, 8'd1, 1'b0, 40, 1'b0);
        run_phase(9'd5, 9'd5, 8'd1, 1'b0, 50, 1'b0);
        run_phase(9'd7, 9'd6, 8'd255, 1'b0, 50, 1'b0);
        run_phase(9'd8, 9'd8, 8'd2, 1'b0, 50, 1'b0);
        run_phase(9'd4, 9'd9, 8'd100, 1'b0, 50, 1'b0);
        run_phase(9'd3, 9'd3, 8'd255, 1'b0, 40, 1'b0);
        run_phase(9'd6, 9'd4, 8'd7, 1'b0, 50, 1'b0);
        run_phase(9'd12, 9'd10, 8'd3, 1'b0, 40, 1'b0);
        run_phase(9'd6, 9'd7, 8'd255, 1'b0, 50, 1'b0);

        // Hold until every response is in, then allow the tail latency.
        drain();
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("binary_image_thinning_unit_tb passed");
        else
            $display("binary_image_thinning_unit_tb failed");
        $finish;
    end

endmodule

// File: sim.f
design/btu_pkg.sv
design/btu_req_if.sv
design/btu_rsp_if.sv
design/btu_ram.sv
design/btu_ctrl.sv
design/btu_dp.sv
design/binary_image_thinning_unit.sv
tb/btu_thin_checker.sv
tb/binary_image_thinning_unit_tb.sv
